@@ design/ccps_pkg.sv @@
`timescale 1ns / 1ps
// Package for the character-class pattern search unit.
// Holds field widths, default sizes, element and request codes and the letter decoder.
// No dependencies.
package ccps_pkg;

    localparam int MAX_PATTERN_DEF = 32;
    localparam int MAX_SOURCE_DEF  = 1024;
    localparam int QUEUE_DEPTH     = 2;

    localparam int CHAR_W    = 8;
    localparam int MASK_W    = 52;
    localparam int KIND_W    = 2;
    localparam int LENGTH_W  = 6;
    localparam int INDEX_W   = 5;
    localparam int POS_OUT_W = 10;

    localparam int LETTERS      = 26;
    localparam int CHAR_LOWER_A = 97;
    localparam int CHAR_UPPER_A = 65;

    typedef enum logic [KIND_W-1:0] {
        KIND_ANY     = 2'd0,
        KIND_CLASS   = 2'd1,
        KIND_NEGATED = 2'd2
    } kind_t;

    typedef enum logic {
        ACT_LOAD = 1'b0,
        ACT_CHAR = 1'b1
    } action_t;

    // One-hot letter position: bits 0-25 for a-z, bits 26-51 for A-Z, none otherwise.
    function automatic logic [MASK_W-1:0] letter_onehot(input logic [CHAR_W-1:0] c);
        logic [MASK_W-1:0] oh;
        oh = '0;
        for (int k = 0; k < LETTERS; k++)
        begin
            oh[k]           = (c == CHAR_W'(CHAR_LOWER_A + k));
            oh[LETTERS + k] = (c == CHAR_W'(CHAR_UPPER_A + k));
        end
        return oh;
    endfunction

endpackage

@@ design/char_class_pattern_search_unit.sv @@
`timescale 1ns / 1ps
// Top level of the character-class pattern search unit.
// Instantiates ccps_front, ccps_queue and ccps_back; depends on ccps_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one request per accepted edge.
//   action = load writes one pattern element (kind, 52-bit letter mask) at
//   element_index; action = char delivers one source byte, last_char marks
//   the end of the string. cfg_we writes pattern_length (0 acts as 1, large
//   values clamp to MAX_PATTERN); write it only while the unit is idle.
//   Output channel (out_valid/out_ready) gives one not-found item, or the
//   matched characters of the earliest occurrence in order, last_of_run set
//   on the final item.
// Timing:
//   One request per cycle while in_ready is high, loads and characters alike:
//   the shift-and update is a single parallel mask-and-shift in the front part.
//   The search enters the queue at the edge that takes the last character; the
//   back part loads its first result item from the queue head into the output
//   register, then one per cycle while out_ready is high (pattern_length items).
//   Two finished searches can wait in the queue; with both slots taken,
//   in_ready drops until the back part pops one.
// Reset:
//   Clears the search state and queue and sets pattern_length to 1; pattern
//   elements hold no value until loaded.
module char_class_pattern_search_unit #(
    parameter int MAX_PATTERN = ccps_pkg::MAX_PATTERN_DEF,
    parameter int MAX_SOURCE  = ccps_pkg::MAX_SOURCE_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            action,
    input  logic [ccps_pkg::INDEX_W-1:0]    element_index,
    input  logic [ccps_pkg::KIND_W-1:0]     element_kind,
    input  logic [ccps_pkg::MASK_W-1:0]     element_mask,
    input  logic [ccps_pkg::CHAR_W-1:0]     source_char,
    input  logic                            last_char,
    input  logic                            cfg_we,
    input  logic [ccps_pkg::LENGTH_W-1:0]   cfg_wdata,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            found,
    output logic [ccps_pkg::POS_OUT_W-1:0]  match_position,
    output logic [ccps_pkg::CHAR_W-1:0]     match_char,
    output logic                            last_of_run
);
    import ccps_pkg::*;

    // Queue entry: found flag, position, run length, captured window.
    localparam int LEN_W   = $clog2(MAX_PATTERN + 1);
    localparam int ENTRY_W = 1 + POS_OUT_W + LEN_W + MAX_PATTERN * CHAR_W;

    logic               push_valid, q_full, q_not_empty, q_pop;
    logic [ENTRY_W-1:0] push_data, head_data;

    // Front: classify requests, run the matcher, close a search on last_char.
    ccps_front #(
        .MAX_PATTERN (MAX_PATTERN),
        .MAX_SOURCE  (MAX_SOURCE),
        .ENTRY_W     (ENTRY_W)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .action        (action),
        .element_index (element_index),
        .element_kind  (element_kind),
        .element_mask  (element_mask),
        .source_char   (source_char),
        .last_char     (last_char),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .queue_full    (q_full),
        .push_valid    (push_valid),
        .push_data     (push_data)
    );

    // Hold finished searches so the front keeps taking characters meanwhile.
    ccps_queue #(
        .DATA_W (ENTRY_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push_valid),
        .push_data (push_data),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head_data (head_data)
    );

    // Back: drain the head search one result item per cycle while out_ready is high.
    ccps_back #(
        .MAX_PATTERN (MAX_PATTERN),
        .ENTRY_W     (ENTRY_W)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head_valid     (q_not_empty),
        .head_data      (head_data),
        .pop            (q_pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .found          (found),
        .match_position (match_position),
        .match_char     (match_char),
        .last_of_run    (last_of_run)
    );

endmodule

@@ design/ccps_front.sv @@
`timescale 1ns / 1ps
// Front part of the pattern search: takes requests, stores pattern elements,
// runs the shift-and update per character and pushes one finished search a time.
// Depends on ccps_pkg.
module ccps_front #(
    parameter int MAX_PATTERN = ccps_pkg::MAX_PATTERN_DEF,
    parameter int MAX_SOURCE  = ccps_pkg::MAX_SOURCE_DEF,
    parameter int ENTRY_W     = 1
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           action,
    input  logic [ccps_pkg::INDEX_W-1:0]   element_index,
    input  logic [ccps_pkg::KIND_W-1:0]    element_kind,
    input  logic [ccps_pkg::MASK_W-1:0]    element_mask,
    input  logic [ccps_pkg::CHAR_W-1:0]    source_char,
    input  logic                           last_char,
    input  logic                           cfg_we,
    input  logic [ccps_pkg::LENGTH_W-1:0]  cfg_wdata,
    input  logic                           queue_full,
    output logic                           push_valid,
    output logic [ENTRY_W-1:0]             push_data
);
    import ccps_pkg::*;

    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int POS_W = $clog2(MAX_SOURCE);
    localparam int CW    = ((POS_W > LEN_W) ? POS_W : LEN_W) + 1;
    localparam int WIN_W = MAX_PATTERN * CHAR_W;
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_SOURCE - 1);

    logic [KIND_W-1:0]      kind_reg   [MAX_PATTERN];
    logic [MASK_W-1:0]      mask_reg   [MAX_PATTERN];
    logic [CHAR_W-1:0]      window_reg [MAX_PATTERN];
    logic [CHAR_W-1:0]      window_next[MAX_PATTERN];
    logic [CHAR_W-1:0]      cap_reg    [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] active_reg, active_next, active_new, mv;
    logic [LEN_W-1:0]       len_reg, len_next, cap_len_reg;
    logic [POS_W-1:0]       count_reg, count_next, first_pos_reg, new_pos;
    logic                   seen_reg, seen_next;
    logic [MASK_W-1:0]      letter_oh;
    logic [CW-1:0]          pos_sum;
    logic                   take, take_char, take_load, hit, capture;
    logic                   run_found;
    logic [POS_W-1:0]       run_pos;
    logic [LEN_W-1:0]       run_len;
    logic [WIN_W-1:0]       run_win;

    assign in_ready  = !queue_full;
    assign take      = in_valid && in_ready;
    assign take_char = take && (action_t'(action) == ACT_CHAR);
    assign take_load = take && (action_t'(action) == ACT_LOAD);

    // Per-element match against the incoming character, one lane per element.
    always_comb
    begin
        letter_oh = letter_onehot(source_char);
        for (int e = 0; e < MAX_PATTERN; e++)
        begin
            case (kind_t'(kind_reg[e]))
                KIND_ANY:     mv[e] = 1'b1;
                KIND_CLASS:   mv[e] = |(mask_reg[e] & letter_oh);
                KIND_NEGATED: mv[e] = !(|(mask_reg[e] & letter_oh));
                default:      mv[e] = 1'b0;
            endcase
            mv[e] = mv[e] && (LEN_W'(e) < len_reg);
        end
        active_new = ((active_reg << 1) | MAX_PATTERN'(1)) & mv;
        hit        = active_new[IDX_W'(len_reg - 1'b1)];
        capture    = !seen_reg && hit;

        window_next[0] = source_char;
        for (int k = 1; k < MAX_PATTERN; k++)
            window_next[k] = window_reg[k-1];

        pos_sum = CW'(count_reg) + CW'(1);
        new_pos = (pos_sum >= CW'(len_reg)) ? POS_W'(pos_sum - CW'(len_reg)) : '0;
    end

    // Result of the search that closes on this character.
    always_comb
    begin
        run_found = seen_reg || hit;
        run_pos   = seen_reg ? first_pos_reg : (hit ? new_pos : '0);
        run_len   = seen_reg ? cap_len_reg : len_reg;
        for (int k = 0; k < MAX_PATTERN; k++)
            run_win[k*CHAR_W +: CHAR_W] = seen_reg ? cap_reg[k] : window_next[k];
    end

    assign push_valid = take_char && last_char;
    assign push_data  = {run_found, POS_OUT_W'(run_pos), run_len, run_win};

    always_comb
    begin
        active_next = active_reg;
        count_next  = count_reg;
        seen_next   = seen_reg;
        len_next    = len_reg;
        if (cfg_we)
        begin
            if (cfg_wdata == '0)
                len_next = LEN_W'(1);
            else if (32'(cfg_wdata) > MAX_PATTERN)
                len_next = LEN_W'(MAX_PATTERN);
            else
                len_next = LEN_W'(cfg_wdata);
        end
        if (take_char)
        begin
            if (last_char)
            begin
                active_next = '0;
                count_next  = '0;
                seen_next   = 1'b0;
            end
            else
            begin
                active_next = active_new;
                count_next  = (count_reg == POS_LAST) ? count_reg : count_reg + 1'b1;
                seen_next   = seen_reg || hit;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= '0;
            count_reg     <= '0;
            seen_reg      <= 1'b0;
            len_reg       <= LEN_W'(1);
            first_pos_reg <= '0;
        end
        else
        begin
            active_reg <= active_next;
            count_reg  <= count_next;
            seen_reg   <= seen_next;
            len_reg    <= len_next;
            if (take_char && (last_char || capture))
                first_pos_reg <= (last_char) ? '0 : new_pos;
        end
    end

    // Element store, character window and captured occurrence: payload only.
    always_ff @(posedge clk)
    begin
        if (take_load && (32'(element_index) < MAX_PATTERN))
        begin
            kind_reg[IDX_W'(element_index)] <= element_kind;
            mask_reg[IDX_W'(element_index)] <= element_mask;
        end
        if (take_char)
        begin
            for (int k = 0; k < MAX_PATTERN; k++)
                window_reg[k] <= window_next[k];
            if (capture)
            begin
                cap_len_reg <= len_reg;
                for (int k = 0; k < MAX_PATTERN; k++)
                    cap_reg[k] <= window_next[k];
            end
        end
    end

endmodule

@@ design/ccps_queue.sv @@
`timescale 1ns / 1ps
// Short queue of finished searches between the front and back parts.
// Depends on ccps_pkg for the default depth.
module ccps_queue #(
    parameter int DATA_W = 1,
    parameter int DEPTH  = ccps_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    input  logic              pop,
    output logic              full,
    output logic              not_empty,
    output logic [DATA_W-1:0] head_data
);
    import ccps_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    logic [DATA_W-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_reg, wr_next, rd_reg, rd_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              do_push, do_pop;

    assign full      = (cnt_reg == CNT_W'(DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head_data = slot_reg[rd_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push)
            wr_next = (wr_reg == PTR_LAST) ? '0 : wr_reg + 1'b1;
        if (do_pop)
            rd_next = (rd_reg == PTR_LAST) ? '0 : rd_reg + 1'b1;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_reg] <= push_data;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("search pushed into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("pop from an empty queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

endmodule

@@ design/ccps_back.sv @@
`timescale 1ns / 1ps
// Back part of the pattern search: walks the search at the queue head and
// emits its result run through an output register. Depends on ccps_pkg.
module ccps_back #(
    parameter int MAX_PATTERN = ccps_pkg::MAX_PATTERN_DEF,
    parameter int ENTRY_W     = 1
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            head_valid,
    input  logic [ENTRY_W-1:0]              head_data,
    output logic                            pop,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            found,
    output logic [ccps_pkg::POS_OUT_W-1:0]  match_position,
    output logic [ccps_pkg::CHAR_W-1:0]     match_char,
    output logic                            last_of_run
);
    import ccps_pkg::*;

    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int WIN_W = MAX_PATTERN * CHAR_W;

    logic [CHAR_W-1:0]    win [MAX_PATTERN];
    logic                 head_found;
    logic [POS_OUT_W-1:0] head_pos;
    logic [LEN_W-1:0]     head_len;
    logic [IDX_W-1:0]     cur, rem_reg, rem_next;
    logic                 started_reg, started_next;
    logic                 valid_reg, valid_next, found_reg, found_next;
    logic                 last_reg, last_next;
    logic [POS_OUT_W-1:0] pos_reg, pos_next;
    logic [CHAR_W-1:0]    char_reg, char_next;
    logic                 load, is_last;

    always_comb
    begin
        for (int k = 0; k < MAX_PATTERN; k++)
            win[k] = head_data[k*CHAR_W +: CHAR_W];
    end
    assign head_len   = head_data[WIN_W +: LEN_W];
    assign head_pos   = head_data[WIN_W + LEN_W +: POS_OUT_W];
    assign head_found = head_data[ENTRY_W-1];

    // Oldest captured character sits at window place len-1; count down to 0.
    assign cur     = started_reg ? rem_reg : IDX_W'(head_len - 1'b1);
    assign load    = head_valid && (!valid_reg || out_ready);
    assign is_last = !head_found || (cur == '0);
    assign pop     = load && is_last;

    always_comb
    begin
        valid_next   = valid_reg;
        found_next   = found_reg;
        pos_next     = pos_reg;
        char_next    = char_reg;
        last_next    = last_reg;
        rem_next     = rem_reg;
        started_next = started_reg;
        if (load)
        begin
            valid_next   = 1'b1;
            found_next   = head_found;
            pos_next     = head_found ? head_pos : '0;
            char_next    = head_found ? win[cur] : '0;
            last_next    = is_last;
            rem_next     = cur - 1'b1;
            started_next = !is_last;
        end
        else if (out_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= 1'b0;
            started_reg <= 1'b0;
        end
        else
        begin
            valid_reg   <= valid_next;
            started_reg <= started_next;
        end
    end

    always_ff @(posedge clk)
    begin
        found_reg <= found_next;
        pos_reg   <= pos_next;
        char_reg  <= char_next;
        last_reg  <= last_next;
        rem_reg   <= rem_next;
    end

    assign out_valid      = valid_reg;
    assign found          = found_reg;
    assign match_position = pos_reg;
    assign match_char     = char_reg;
    assign last_of_run    = last_reg;

    a_notfound_single: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !found_reg |-> last_reg && (char_reg == '0) && (pos_reg == '0))
        else $error("not-found result must be a single zero item");

    a_run_holds_head: assert property (@(posedge clk) disable iff (!rst_n)
        started_reg |-> head_valid && head_found)
        else $error("run in progress lost its queue entry");

endmodule
